### hdl/tpst_pkg.sv
package tpst_pkg;

    localparam int PCR_W        = 42;
    localparam int PID_W        = 13;
    localparam int SLOT_W       = 4;
    localparam int POS_W        = 8;
    localparam int PACKET_BYTES = 188;
    localparam logic [7:0] SYNC_BYTE = 8'h47;

    // byte positions inside a packet
    localparam logic [POS_W-1:0] POS_SYNC    = 8'd0;
    localparam logic [POS_W-1:0] POS_PID_HI  = 8'd1;
    localparam logic [POS_W-1:0] POS_PID_LO  = 8'd2;
    localparam logic [POS_W-1:0] POS_AFC     = 8'd3;
    localparam logic [POS_W-1:0] POS_AF_LEN  = 8'd4;
    localparam logic [POS_W-1:0] POS_FLAGS   = 8'd5;
    localparam logic [POS_W-1:0] POS_BASE0   = 8'd6;
    localparam logic [POS_W-1:0] POS_BASE1   = 8'd7;
    localparam logic [POS_W-1:0] POS_BASE2   = 8'd8;
    localparam logic [POS_W-1:0] POS_BASE3   = 8'd9;
    localparam logic [POS_W-1:0] POS_BASE_EX = 8'd10;
    localparam logic [POS_W-1:0] POS_EXT_LO  = 8'd11;
    localparam logic [POS_W-1:0] POS_LAST    = 8'd187;

    // base * 300 = base<<8 + base<<5 + base<<3 + base<<2, then the extension MSB
    localparam logic [2:0] MUL_LAST_STEP = 3'd4;

    typedef enum logic [2:0] {
        KIND_UPDATE  = 3'd0,
        KIND_NEW_ID  = 3'd1,
        KIND_FULL    = 3'd2,
        KIND_NO_SYNC = 3'd3,
        KIND_SLOT    = 3'd4,
        KIND_EMPTY   = 3'd5
    } kind_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL,
        S_ADDB,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_UPD,
        S_NEW,
        S_RD_OUT,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic [PID_W-1:0] id;
        logic [PCR_W-1:0] first;
        logic [PCR_W-1:0] latest;
    } slot_rec_t;

    typedef struct packed {
        kind_t             kind;
        logic [PID_W-1:0]  id;
        logic [SLOT_W-1:0] slot;
        logic [PCR_W-1:0]  first;
        logic [PCR_W-1:0]  latest;
        logic [PCR_W-1:0]  span;
    } result_t;

endpackage

### hdl/tpst_addsub.sv
module tpst_addsub (
    input  logic [tpst_pkg::PCR_W-1:0] a,
    input  logic [tpst_pkg::PCR_W-1:0] b,
    input  logic                       sub,
    output logic [tpst_pkg::PCR_W-1:0] sum
);
    import tpst_pkg::*;

    logic [PCR_W-1:0] b_op;

    always_comb begin
        b_op = sub ? ~b : b;
        sum  = a + b_op + PCR_W'(sub);
    end

endmodule

### hdl/tpst_slot_mem.sv
module tpst_slot_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic                aclk,
    input  logic                we,
    input  logic [AW-1:0]       waddr,
    input  tpst_pkg::slot_rec_t wdata,
    input  logic                re,
    input  logic [AW-1:0]       raddr,
    output tpst_pkg::slot_rec_t rdata
);
    import tpst_pkg::*;

    slot_rec_t mem [DEPTH];
    slot_rec_t rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### hdl/ts_pcr_span_tracker.sv
// Transport stream PCR span tracker.
// Slave channel: one beat per stream byte (s_tuser = 0) or one slot read request
// (s_tuser = 1). Packets are 188 bytes; the first byte of each must be 0x47.
// Master channel: at most one result beat per input beat: a PCR update, a new
// packet id, table full, missing sync, one slot's contents, or an empty slot.
// A plain stream byte leaves the sequencer idle, so such beats can follow back to
// back. The fifth PCR byte (position 10) runs the 42-bit shared adder through
// five shift-add steps that form base * 300 plus the extension MSB; the low
// extension byte is added when the last PCR byte of a PCR packet arrives. That
// byte then searches the table for the packet id, reading one slot id and
// comparing it at a time through the single memory port, and ends in an update,
// a new id, or table full. A slot read goes through a memory read before its
// result; an empty slot read or a missing sync byte goes straight to the result.
// s_tready is high only while the sequencer is idle.
// A result waits in the output register; a new beat may be accepted while it
// waits, but the next result holds the sequencer until the receiver takes it.
// Reset clears the byte position, packet state and fill count; the slot
// table is filled in order, so slots below the fill count are the valid ones
// and no clearing pass is needed.
module ts_pcr_span_tracker #(
    parameter int TABLE_SLOTS = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [15:0]  s_tdata,   // data_byte[7:0], read_slot[11:8], zero pad
    input  logic         s_tuser,   // action
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [143:0] m_tdata,   // packet_id[12:0], slot_number[16:13],
                                    // first_pcr[58:17], latest_pcr[100:59],
                                    // span_ticks[142:101], zero pad
    output logic [2:0]   m_tuser    // kind
);
    import tpst_pkg::*;

    localparam int AW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int CW = $clog2(TABLE_SLOTS + 1);

    state_t state_reg, state_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic alive_reg, alive_next;
    logic [PID_W-1:0] held_reg, held_next;
    logic [PCR_W-1:0] acc_reg, acc_next;
    logic [32:0] base_reg, base_next;
    logic ext_reg, ext_next;
    logic [2:0] step_reg, step_next;
    logic [CW-1:0] used_reg, used_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [7:0] byte_reg, byte_next;
    logic [SLOT_W-1:0] rslot_reg, rslot_next;
    result_t res_reg, res_next;
    result_t out_reg, out_next;
    logic m_valid_reg, m_valid_next;

    logic accept;
    logic [7:0] in_byte;
    logic [SLOT_W-1:0] in_slot;
    logic rd_ok;

    logic [PCR_W-1:0] add_a, add_b, add_sum;
    logic add_sub;

    logic mem_we, mem_re;
    logic [AW-1:0] mem_waddr, mem_raddr;
    slot_rec_t mem_wdata, mem_rdata;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign in_byte  = s_tdata[7:0];
    assign in_slot  = s_tdata[11:8];
    assign rd_ok    = (32'(in_slot) < TABLE_SLOTS) && (32'(in_slot) < 32'(used_reg));

    tpst_addsub u_addsub (
        .a   (add_a),
        .b   (add_b),
        .sub (add_sub),
        .sum (add_sum)
    );

    tpst_slot_mem #(
        .DEPTH (TABLE_SLOTS),
        .AW    (AW)
    ) u_slot_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    always_comb begin
        state_next   = state_reg;
        pos_next     = pos_reg;
        alive_next   = alive_reg;
        held_next    = held_reg;
        acc_next     = acc_reg;
        base_next    = base_reg;
        ext_next     = ext_reg;
        step_next    = step_reg;
        used_next    = used_reg;
        idx_next     = idx_reg;
        byte_next    = byte_reg;
        rslot_next   = rslot_reg;
        res_next     = res_reg;
        out_next     = out_reg;
        m_valid_next = m_valid_reg;
        add_a        = acc_reg;
        add_b        = '0;
        add_sub      = 1'b0;
        mem_we       = 1'b0;
        mem_re       = 1'b0;
        mem_waddr    = idx_reg[AW-1:0];
        mem_raddr    = idx_reg[AW-1:0];
        mem_wdata    = '{id: held_reg, first: acc_reg, latest: acc_reg};

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    byte_next  = in_byte;
                    rslot_next = in_slot;
                    if (s_tuser) begin
                        if (rd_ok) begin
                            mem_re     = 1'b1;
                            mem_raddr  = AW'(in_slot);
                            state_next = S_RD_OUT;
                        end else begin
                            res_next   = '{kind: KIND_EMPTY, id: '0, slot: in_slot,
                                           first: '0, latest: '0, span: '0};
                            state_next = S_EMIT;
                        end
                    end else begin
                        pos_next = (pos_reg == POS_LAST) ? POS_SYNC : pos_reg + 8'd1;
                        unique case (pos_reg)
                            POS_SYNC: begin
                                alive_next = (in_byte == SYNC_BYTE);
                                held_next  = '0;
                                acc_next   = '0;
                                if (in_byte != SYNC_BYTE) begin
                                    res_next   = '{kind: KIND_NO_SYNC, id: '0, slot: '0,
                                                   first: '0, latest: '0, span: '0};
                                    state_next = S_EMIT;
                                end
                            end
                            POS_PID_HI: held_next = {in_byte[4:0], 8'd0};
                            POS_PID_LO: held_next = held_reg | PID_W'(in_byte);
                            POS_AFC: begin
                                // adaptation field present when control is 2 or 3
                                if (!in_byte[5]) begin
                                    alive_next = 1'b0;
                                end
                            end
                            POS_AF_LEN: begin
                                if (in_byte == 8'd0) begin
                                    alive_next = 1'b0;
                                end
                            end
                            POS_FLAGS: begin
                                if (!in_byte[4]) begin
                                    alive_next = 1'b0;
                                end
                            end
                            POS_BASE0, POS_BASE1, POS_BASE2, POS_BASE3: begin
                                acc_next = PCR_W'({acc_reg[23:0], in_byte});
                            end
                            POS_BASE_EX: begin
                                base_next  = {acc_reg[31:0], in_byte[7]};
                                ext_next   = in_byte[0];
                                acc_next   = '0;
                                step_next  = '0;
                                state_next = S_MUL;
                            end
                            POS_EXT_LO: begin
                                if (alive_reg) begin
                                    alive_next = 1'b0;
                                    state_next = S_ADDB;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
            end

            S_MUL: begin
                unique case (step_reg)
                    3'd0:    add_b = PCR_W'(base_reg) << 8;
                    3'd1:    add_b = PCR_W'(base_reg) << 5;
                    3'd2:    add_b = PCR_W'(base_reg) << 3;
                    3'd3:    add_b = PCR_W'(base_reg) << 2;
                    default: add_b = PCR_W'(ext_reg) << 8;
                endcase
                acc_next  = add_sum;
                step_next = step_reg + 3'd1;
                if (step_reg == MUL_LAST_STEP) begin
                    state_next = S_IDLE;
                end
            end

            S_ADDB: begin
                add_b      = PCR_W'(byte_reg);
                acc_next   = add_sum;
                idx_next   = '0;
                state_next = S_SRCH_RD;
            end

            S_SRCH_RD: begin
                if (idx_reg < used_reg) begin
                    mem_re     = 1'b1;
                    state_next = S_SRCH_CMP;
                end else if (32'(used_reg) < TABLE_SLOTS) begin
                    state_next = S_NEW;
                end else begin
                    res_next   = '{kind: KIND_FULL, id: held_reg, slot: '0,
                                   first: '0, latest: acc_reg, span: '0};
                    state_next = S_EMIT;
                end
            end

            S_SRCH_CMP: begin
                if (mem_rdata.id == held_reg) begin
                    state_next = S_UPD;
                end else begin
                    idx_next   = idx_reg + CW'(1);
                    state_next = S_SRCH_RD;
                end
            end

            S_UPD: begin
                mem_we     = 1'b1;
                mem_wdata  = '{id: held_reg, first: mem_rdata.first, latest: acc_reg};
                add_b      = mem_rdata.first;
                add_sub    = 1'b1;
                res_next   = '{kind: KIND_UPDATE, id: held_reg, slot: SLOT_W'(idx_reg),
                               first: mem_rdata.first, latest: acc_reg, span: add_sum};
                state_next = S_EMIT;
            end

            S_NEW: begin
                mem_we     = 1'b1;
                mem_waddr  = used_reg[AW-1:0];
                used_next  = used_reg + CW'(1);
                res_next   = '{kind: KIND_NEW_ID, id: held_reg, slot: SLOT_W'(used_reg),
                               first: acc_reg, latest: acc_reg, span: '0};
                state_next = S_EMIT;
            end

            S_RD_OUT: begin
                add_a      = mem_rdata.latest;
                add_b      = mem_rdata.first;
                add_sub    = 1'b1;
                res_next   = '{kind: KIND_SLOT, id: mem_rdata.id, slot: rslot_reg,
                               first: mem_rdata.first, latest: mem_rdata.latest,
                               span: add_sum};
                state_next = S_EMIT;
            end

            S_EMIT: begin
                // hold the result until the output register frees up
                if (!m_valid_reg || m_tready) begin
                    out_next     = res_reg;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end

            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            pos_reg     <= '0;
            alive_reg   <= 1'b0;
            held_reg    <= '0;
            acc_reg     <= '0;
            used_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            pos_reg     <= pos_next;
            alive_reg   <= alive_next;
            held_reg    <= held_next;
            acc_reg     <= acc_next;
            used_reg    <= used_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        base_reg  <= base_next;
        ext_reg   <= ext_next;
        step_reg  <= step_next;
        idx_reg   <= idx_next;
        byte_reg  <= byte_next;
        rslot_reg <= rslot_next;
        res_reg   <= res_next;
        out_reg   <= out_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = out_reg.kind;
    assign m_tdata  = {1'b0, out_reg.span, out_reg.latest, out_reg.first,
                       out_reg.slot, out_reg.id};

`ifndef ASSERT_OFF
    a_busy_after_read: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser |=> !s_tready)
        else $error("slot read accepted without going busy");

    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(pos_reg) < PACKET_BYTES)
        else $error("byte position out of packet");

    a_used_range: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(used_reg) <= TABLE_SLOTS)
        else $error("slot fill count beyond table");

    a_new_has_room: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_NEW |-> 32'(used_reg) < TABLE_SLOTS)
        else $error("new slot taken from a full table");

    a_read_consumed: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_re |=> state_reg == S_SRCH_CMP || state_reg == S_RD_OUT)
        else $error("slot read data not consumed");
`endif

endmodule
